[design/stkcpu_pkg.sv]
package stkcpu_pkg;

    // word memory geometry
    localparam int MEM_WORDS = 32768;
    localparam int MEM_AW    = $clog2(MEM_WORDS);

    // stack window and code segment
    localparam logic signed [15:0] STACK_BASE  = 16'sd4096;
    localparam logic signed [15:0] STACK_LIMIT = 16'sd12288;
    localparam logic [15:0]        CODE_TOP    = 16'h0FFF;

    // register indexes
    localparam logic [2:0] R_CX  = 3'd2;
    localparam logic [2:0] R_SP  = 3'd3;
    localparam logic [2:0] R_MA  = 3'd5;
    localparam logic [2:0] R_MAX = 3'd5;

    // item codes
    typedef enum logic [1:0] {
        ITEM_LOAD    = 2'd0,
        ITEM_RESTART = 2'd1,
        ITEM_EXEC    = 2'd2,
        ITEM_NONE    = 2'd3
    } item_op_t;

    // instruction opcodes
    typedef enum logic [3:0] {
        OP_NOP   = 4'd0,
        OP_ADD   = 4'd1,
        OP_SUB   = 4'd2,
        OP_MULT  = 4'd3,
        OP_DIV   = 4'd4,
        OP_PUSH  = 4'd5,
        OP_POP   = 4'd6,
        OP_MOV   = 4'd7,
        OP_LOAD  = 4'd8,
        OP_STORE = 4'd9,
        OP_JMP   = 4'd10,
        OP_JNZ   = 4'd11,
        OP_JZ    = 4'd12,
        OP_JN    = 4'd13,
        OP_CALL  = 4'd14,
        OP_RET   = 4'd15
    } instr_op_t;

    // fault codes
    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_OVF    = 3'd1;
    localparam logic [2:0] ERR_UNF    = 3'd2;
    localparam logic [2:0] ERR_BADREG = 3'd3;
    localparam logic [2:0] ERR_BADADR = 3'd4;
    localparam logic [2:0] ERR_DIVZ   = 3'd5;

endpackage

[design/stack_cpu16_instruction_executor_top.sv]
// 16-bit word machine executor. Each accepted word loads a program word, restarts at
// start_address, fetches and executes one instruction unless a fault is held, or is an
// idle word; one result word follows each. An instruction is a fetch read, an execute
// and a result; pop, load and ret add one more memory read, and div runs a 16-step
// restoring divider one quotient bit a cycle.
// The single-port read of the word memory, with registered read data, sets the fetch
// and operand latency. The block takes one word at a time; s_ready is low while busy.
module stack_cpu16_instruction_executor_top import stkcpu_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [11:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_opcode,
    input  logic [15:0]        s_instr_word,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_pc,
    output logic signed [15:0] m_ax,
    output logic signed [15:0] m_bx,
    output logic signed [15:0] m_cx,
    output logic signed [15:0] m_sp,
    output logic signed [15:0] m_bp,
    output logic signed [15:0] m_ma,
    output logic [2:0]         m_error_code,
    output logic               m_code_access_warning
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EXEC,
        ST_MEMRD,
        ST_MEMFIN,
        ST_DIV,
        ST_DIVFIN,
        ST_RESP
    } state_t;

    state_t             state_reg;
    logic [15:0]        rf_reg [6];
    logic [15:0]        pc_reg;
    logic [15:0]        lp_reg;
    logic [11:0]        start_reg;
    logic [2:0]         err_reg;
    logic               warn_reg;
    logic [15:0]        ir_reg;
    logic [MEM_AW-1:0]  rd_addr_reg;
    logic [15:0]        rd_data_reg;
    logic [16:0]        rem_reg;
    logic [15:0]        quo_reg;
    logic [15:0]        dvs_reg;
    logic [3:0]         cnt_reg;
    logic               qneg_reg;
    logic               rneg_reg;
    logic               m_valid_reg;

    logic [15:0] mem [MEM_WORDS];

    // decode
    logic [15:0]        ir;
    instr_op_t          op;
    logic [2:0]         dst;
    logic [2:0]         rs;
    logic [11:0]        target;
    logic               src_ok;
    logic               dst_ok;
    logic               wide;
    logic [15:0]        src_val;
    logic [15:0]        dst_val;
    logic signed [15:0] sp_s;
    logic signed [15:0] ma_s;
    logic [15:0]        sp_dec;
    logic [2:0]         push_err;
    logic [2:0]         pop_err;
    logic               ma_bad;
    logic               take;
    logic [2:0]         exec_err;
    logic [31:0]        prod;

    assign ir     = (state_reg == ST_EXEC) ? rd_data_reg : ir_reg;
    assign op     = instr_op_t'(ir[15:12]);
    assign dst    = ir[2:0];
    assign rs     = ir[5:3];
    assign target = ir[11:0];
    assign wide   = (op == OP_PUSH) || (op == OP_STORE);
    assign src_ok = !ir[11] || (rs <= R_MAX);
    assign dst_ok = dst <= R_MAX;
    assign sp_s   = rf_reg[R_SP];
    assign ma_s   = rf_reg[R_MA];
    assign sp_dec = rf_reg[R_SP] - 16'd1;
    assign dst_val = rf_reg[dst];
    assign prod   = dst_val * src_val;

    // source operand: register or immediate
    always_comb begin
        if (ir[11]) begin
            src_val = rf_reg[rs];
        end else if (wide) begin
            src_val = {5'd0, ir[10:0]};
        end else begin
            src_val = {8'd0, ir[10:3]};
        end
    end

    // stack and address checks
    always_comb begin
        push_err = ERR_NONE;
        if (sp_s > STACK_LIMIT - 16'sd1) begin
            push_err = ERR_OVF;
        end else if (sp_s < STACK_BASE) begin
            push_err = ERR_UNF;
        end
        pop_err = ERR_NONE;
        if (sp_s > STACK_LIMIT) begin
            pop_err = ERR_OVF;
        end else if (sp_s <= STACK_BASE) begin
            pop_err = ERR_UNF;
        end
        ma_bad = ma_s[15] || ({1'b0, ma_s} >= 17'(MEM_WORDS));
    end

    // fault of the current instruction
    always_comb begin
        take     = 1'b0;
        exec_err = ERR_NONE;
        case (op)
            OP_NOP: begin
                exec_err = ERR_NONE;
            end
            OP_ADD, OP_SUB, OP_MULT, OP_MOV, OP_DIV: begin
                if (!src_ok || !dst_ok) begin
                    exec_err = ERR_BADREG;
                end else if (op == OP_DIV && src_val == 16'd0) begin
                    exec_err = ERR_DIVZ;
                end
            end
            OP_PUSH: begin
                exec_err = !src_ok ? ERR_BADREG : push_err;
            end
            OP_POP: begin
                exec_err = !dst_ok ? ERR_BADREG : pop_err;
            end
            OP_LOAD: begin
                exec_err = !dst_ok ? ERR_BADREG : (ma_bad ? ERR_BADADR : ERR_NONE);
            end
            OP_STORE: begin
                exec_err = !src_ok ? ERR_BADREG : (ma_bad ? ERR_BADADR : ERR_NONE);
            end
            OP_JMP, OP_JNZ, OP_JZ, OP_JN: begin
                case (op)
                    OP_JMP:  take = 1'b1;
                    OP_JNZ:  take = rf_reg[R_CX] != 16'd0;
                    OP_JZ:   take = rf_reg[R_CX] == 16'd0;
                    default: take = rf_reg[R_CX][15];
                endcase
                exec_err = (take && target == 12'd0) ? ERR_BADADR : ERR_NONE;
            end
            OP_CALL: begin
                exec_err = (target == 12'd0) ? ERR_BADADR : push_err;
            end
            default: begin
                exec_err = pop_err;
            end
        endcase
    end

    // memory write port
    logic              mem_we;
    logic [MEM_AW-1:0] mem_waddr;
    logic [15:0]       mem_wdata;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = lp_reg[MEM_AW-1:0];
        mem_wdata = s_instr_word;
        if (state_reg == ST_IDLE) begin
            mem_we = s_valid && item_op_t'(s_opcode) == ITEM_LOAD;
        end else if (state_reg == ST_EXEC && exec_err == ERR_NONE) begin
            case (op)
                OP_PUSH: begin
                    mem_we    = 1'b1;
                    mem_waddr = rf_reg[R_SP][MEM_AW-1:0];
                    mem_wdata = src_val;
                end
                OP_CALL: begin
                    mem_we    = 1'b1;
                    mem_waddr = rf_reg[R_SP][MEM_AW-1:0];
                    mem_wdata = pc_reg;
                end
                OP_STORE: begin
                    mem_we    = 1'b1;
                    mem_waddr = rf_reg[R_MA][MEM_AW-1:0];
                    mem_wdata = src_val;
                end
                default: begin
                    mem_we = 1'b0;
                end
            endcase
        end
    end

    // word memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr_reg];
    end

    // divider step
    logic [16:0] div_trial;
    logic [16:0] div_diff;
    assign div_trial = {rem_reg[15:0], quo_reg[15]};
    assign div_diff  = div_trial - {1'b0, dvs_reg};

    // divide result with signs applied
    logic [15:0] div_q;
    logic [15:0] div_r;
    assign div_q = qneg_reg ? 16'(-quo_reg) : quo_reg;
    assign div_r = rneg_reg ? 16'(-rem_reg[15:0]) : rem_reg[15:0];

    // sequencer, architectural state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            for (int i = 0; i < 6; i++) begin
                rf_reg[i] <= 16'd0;
            end
            rf_reg[R_SP] <= STACK_BASE;
            pc_reg      <= 16'd1;
            lp_reg      <= 16'd1;
            start_reg   <= 12'd1;
            err_reg     <= ERR_NONE;
            warn_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // result taken and no new one ready this cycle
            if (m_valid_reg && m_ready && state_reg != ST_RESP) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                start_reg <= cfg_wr_data;
                lp_reg    <= {4'd0, cfg_wr_data};
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        warn_reg  <= 1'b0;
                        state_reg <= ST_RESP;
                        case (item_op_t'(s_opcode))
                            ITEM_LOAD: begin
                                lp_reg <= lp_reg + 16'd1;
                            end
                            ITEM_RESTART: begin
                                pc_reg  <= {4'd0, start_reg};
                                err_reg <= ERR_NONE;
                            end
                            ITEM_EXEC: begin
                                if (err_reg == ERR_NONE) begin
                                    rd_addr_reg <= pc_reg[MEM_AW-1:0];
                                    state_reg   <= ST_FETCH;
                                end
                            end
                            default: begin
                                state_reg <= ST_RESP;
                            end
                        endcase
                    end
                end
                ST_FETCH: begin
                    state_reg <= ST_EXEC;
                end
                ST_EXEC: begin
                    ir_reg    <= rd_data_reg;
                    state_reg <= ST_RESP;
                    if (exec_err != ERR_NONE) begin
                        err_reg <= exec_err;
                    end else begin
                        pc_reg <= pc_reg + 16'd1;
                        case (op)
                            OP_ADD:  rf_reg[dst] <= dst_val + src_val;
                            OP_SUB:  rf_reg[dst] <= dst_val - src_val;
                            OP_MULT: rf_reg[dst] <= prod[15:0];
                            OP_MOV:  rf_reg[dst] <= src_val;
                            OP_DIV: begin
                                rem_reg   <= 17'd0;
                                quo_reg   <= dst_val[15] ? 16'(-dst_val) : dst_val;
                                dvs_reg   <= src_val[15] ? 16'(-src_val) : src_val;
                                qneg_reg  <= dst_val[15] ^ src_val[15];
                                rneg_reg  <= dst_val[15];
                                cnt_reg   <= 4'd0;
                                state_reg <= ST_DIV;
                            end
                            OP_PUSH: begin
                                rf_reg[R_SP] <= rf_reg[R_SP] + 16'd1;
                            end
                            OP_POP: begin
                                rd_addr_reg <= sp_dec[MEM_AW-1:0];
                                state_reg   <= ST_MEMRD;
                            end
                            OP_RET: begin
                                rd_addr_reg <= sp_dec[MEM_AW-1:0];
                                pc_reg      <= pc_reg;
                                state_reg   <= ST_MEMRD;
                            end
                            OP_LOAD: begin
                                rd_addr_reg <= rf_reg[R_MA][MEM_AW-1:0];
                                warn_reg    <= rf_reg[R_MA] <= CODE_TOP;
                                state_reg   <= ST_MEMRD;
                            end
                            OP_STORE: begin
                                warn_reg <= rf_reg[R_MA] <= CODE_TOP;
                            end
                            OP_JMP, OP_JNZ, OP_JZ, OP_JN: begin
                                if (take) begin
                                    pc_reg <= {4'd0, target};
                                end
                            end
                            OP_CALL: begin
                                rf_reg[R_SP] <= rf_reg[R_SP] + 16'd1;
                                pc_reg       <= {4'd0, target};
                            end
                            default: begin
                                pc_reg <= pc_reg + 16'd1;
                            end
                        endcase
                    end
                end
                ST_MEMRD: begin
                    state_reg <= ST_MEMFIN;
                end
                ST_MEMFIN: begin
                    state_reg <= ST_RESP;
                    case (op)
                        OP_POP: begin
                            rf_reg[R_SP] <= rf_reg[R_SP] - 16'd1;
                            rf_reg[dst]  <= rd_data_reg;
                        end
                        OP_RET: begin
                            if (rd_data_reg > CODE_TOP) begin
                                err_reg <= ERR_BADADR;
                            end else begin
                                rf_reg[R_SP] <= rf_reg[R_SP] - 16'd1;
                                pc_reg       <= rd_data_reg + 16'd1;
                            end
                        end
                        default: begin
                            rf_reg[dst] <= rd_data_reg;
                        end
                    endcase
                end
                ST_DIV: begin
                    if (div_diff[16]) begin
                        rem_reg <= div_trial;
                        quo_reg <= {quo_reg[14:0], 1'b0};
                    end else begin
                        rem_reg <= div_diff;
                        quo_reg <= {quo_reg[14:0], 1'b1};
                    end
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15) begin
                        state_reg <= ST_DIVFIN;
                    end
                end
                ST_DIVFIN: begin
                    // remainder wins when cx is also the destination
                    rf_reg[dst]  <= div_q;
                    rf_reg[R_CX] <= div_r;
                    state_reg    <= ST_RESP;
                end
                ST_RESP: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg           <= 1'b1;
                        m_pc                  <= pc_reg;
                        m_ax                  <= rf_reg[0];
                        m_bx                  <= rf_reg[1];
                        m_cx                  <= rf_reg[2];
                        m_sp                  <= rf_reg[3];
                        m_bp                  <= rf_reg[4];
                        m_ma                  <= rf_reg[5];
                        m_error_code          <= err_reg;
                        m_code_access_warning <= (err_reg == ERR_NONE) && warn_reg;
                        state_reg             <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;

endmodule

[sim/tb_top.sv]
module tb_top;
    import stkcpu_pkg::*;

    localparam logic [2:0] R_AX = 3'd0;
    localparam logic [2:0] R_BX = 3'd1;
    localparam logic [2:0] R_BP = 3'd4;

    typedef struct packed {
        logic [15:0] pc;
        logic [15:0] ax;
        logic [15:0] bx;
        logic [15:0] cx;
        logic [15:0] sp;
        logic [15:0] bp;
        logic [15:0] ma;
        logic [2:0]  err;
        logic        warn;
    } cpu_view_t;

    // machine model and the queue of predicted result words
    class cpu_scoreboard;
        bit [15:0]  mem [MEM_WORDS];
        bit         written [MEM_WORDS];
        bit [15:0]  rf [6];
        bit [15:0]  pc;
        bit [15:0]  lp;
        bit [2:0]   halt_err;
        bit [11:0]  start;
        cpu_view_t  pending_q [$];
        int         errors;

        function new();
            foreach (rf[i]) rf[i] = 16'd0;
            rf[R_SP] = 16'd4096;
            pc = 16'd1;
            lp = 16'd1;
            halt_err = ERR_NONE;
            start = 12'd1;
            errors = 0;
        endfunction

        function void set_start(bit [11:0] v);
            start = v;
            lp = {4'd0, v};
        endfunction

        function int sx(bit [15:0] v);
            return int'($signed(v));
        endfunction

        function bit get_src(bit [15:0] ir, bit wide, output bit [15:0] src);
            src = 16'd0;
            if (ir[11]) begin
                if (ir[5:3] > R_MAX) return 0;
                src = rf[ir[5:3]];
            end else begin
                src = wide ? {5'd0, ir[10:0]} : {8'd0, ir[10:3]};
            end
            return 1;
        endfunction

        function bit [2:0] push_err();
            if (sx(rf[R_SP]) > 12287) return ERR_OVF;
            if (sx(rf[R_SP]) < 4096) return ERR_UNF;
            return ERR_NONE;
        endfunction

        function bit [2:0] pop_err();
            if (sx(rf[R_SP]) > 12288) return ERR_OVF;
            if (sx(rf[R_SP]) <= 4096) return ERR_UNF;
            return ERR_NONE;
        endfunction

        // true when the next execute word reads only words already written
        function bit exec_safe();
            bit [15:0] ir;
            int ma_i;
            int sp_i;
            if (!written[pc[MEM_AW-1:0]]) return 0;
            if (halt_err != ERR_NONE) return 1;
            ir = mem[pc[MEM_AW-1:0]];
            ma_i = sx(rf[R_MA]);
            sp_i = sx(rf[R_SP]);
            if (ir[15:12] == OP_POP || ir[15:12] == OP_RET) begin
                if (sp_i > 4096 && sp_i <= 12288 && !written[15'(sp_i - 1)]) return 0;
            end
            if (ir[15:12] == OP_LOAD) begin
                if (ma_i >= 0 && ma_i < MEM_WORDS && !written[15'(ma_i)]) return 0;
            end
            return 1;
        endfunction

        function bit [2:0] run_instr(output bit warn);
            bit [15:0] ir;
            bit [15:0] src;
            bit [15:0] nxt;
            bit [15:0] tgt;
            bit [15:0] v;
            bit [2:0]  d;
            bit [2:0]  e;
            int        ma_i;
            int        a;
            int        b;
            bit        take;
            warn = 0;
            ir = mem[pc[MEM_AW-1:0]];
            d = ir[2:0];
            tgt = {4'd0, ir[11:0]};
            nxt = pc + 16'd1;
            ma_i = sx(rf[R_MA]);
            take = 0;
            case (instr_op_t'(ir[15:12]))
                OP_NOP: ;
                OP_ADD, OP_SUB, OP_MULT, OP_DIV, OP_MOV: begin
                    if (!get_src(ir, 0, src) || d > R_MAX) return ERR_BADREG;
                    case (instr_op_t'(ir[15:12]))
                        OP_ADD:  rf[d] = rf[d] + src;
                        OP_SUB:  rf[d] = rf[d] - src;
                        OP_MULT: rf[d] = rf[d] * src;
                        OP_MOV:  rf[d] = src;
                        default: begin
                            a = sx(rf[d]);
                            b = sx(src);
                            if (b == 0) return ERR_DIVZ;
                            rf[d] = 16'(a / b);
                            rf[R_CX] = 16'(a % b);
                        end
                    endcase
                end
                OP_PUSH: begin
                    if (!get_src(ir, 1, src)) return ERR_BADREG;
                    e = push_err();
                    if (e != ERR_NONE) return e;
                    mem[rf[R_SP][MEM_AW-1:0]] = src;
                    written[rf[R_SP][MEM_AW-1:0]] = 1;
                    rf[R_SP] = rf[R_SP] + 16'd1;
                end
                OP_POP: begin
                    if (d > R_MAX) return ERR_BADREG;
                    e = pop_err();
                    if (e != ERR_NONE) return e;
                    rf[R_SP] = rf[R_SP] - 16'd1;
                    rf[d] = mem[rf[R_SP][MEM_AW-1:0]];
                end
                OP_LOAD: begin
                    if (d > R_MAX) return ERR_BADREG;
                    if (ma_i < 0 || ma_i >= MEM_WORDS) return ERR_BADADR;
                    rf[d] = mem[15'(ma_i)];
                    warn = ma_i <= CODE_TOP;
                end
                OP_STORE: begin
                    if (!get_src(ir, 1, src)) return ERR_BADREG;
                    if (ma_i < 0 || ma_i >= MEM_WORDS) return ERR_BADADR;
                    mem[15'(ma_i)] = src;
                    written[15'(ma_i)] = 1;
                    warn = ma_i <= CODE_TOP;
                end
                OP_JMP: take = 1;
                OP_JNZ: take = rf[R_CX] != 16'd0;
                OP_JZ:  take = rf[R_CX] == 16'd0;
                OP_JN:  take = rf[R_CX][15];
                OP_CALL: begin
                    if (tgt == 16'd0) return ERR_BADADR;
                    e = push_err();
                    if (e != ERR_NONE) return e;
                    mem[rf[R_SP][MEM_AW-1:0]] = pc;
                    written[rf[R_SP][MEM_AW-1:0]] = 1;
                    rf[R_SP] = rf[R_SP] + 16'd1;
                    nxt = tgt;
                end
                default: begin
                    e = pop_err();
                    if (e != ERR_NONE) return e;
                    v = mem[15'(rf[R_SP] - 16'd1)];
                    if (v > CODE_TOP) return ERR_BADADR;
                    rf[R_SP] = rf[R_SP] - 16'd1;
                    nxt = v + 16'd1;
                end
            endcase
            if (take) begin
                if (tgt == 16'd0) return ERR_BADADR;
                nxt = tgt;
            end
            pc = nxt;
            return ERR_NONE;
        endfunction

        // note an accepted input word and predict its result word
        function void note_input(bit [1:0] op, bit [15:0] word);
            cpu_view_t r;
            bit [2:0]  e;
            bit        w;
            w = 0;
            case (item_op_t'(op))
                ITEM_LOAD: begin
                    mem[lp[MEM_AW-1:0]] = word;
                    written[lp[MEM_AW-1:0]] = 1;
                    lp = lp + 16'd1;
                end
                ITEM_RESTART: begin
                    pc = {4'd0, start};
                    halt_err = ERR_NONE;
                end
                ITEM_EXEC: begin
                    if (halt_err == ERR_NONE) begin
                        e = run_instr(w);
                        if (e != ERR_NONE) begin
                            halt_err = e;
                            w = 0;
                        end
                    end
                end
                default: ;
            endcase
            r.pc = pc;
            r.ax = rf[0];
            r.bx = rf[1];
            r.cx = rf[2];
            r.sp = rf[3];
            r.bp = rf[4];
            r.ma = rf[5];
            r.err = halt_err;
            r.warn = w;
            pending_q.push_back(r);
        endfunction

        function void cmp(string n, logic [15:0] e, logic [15:0] a);
            if (e !== a) begin
                $display("%0t: %s expected %h actual %h", $time, n, e, a);
                errors++;
            end
        endfunction

        // compare a result word with the oldest prediction
        function void check_result(cpu_view_t a);
            cpu_view_t e;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result word, expected none actual pc %h",
                         $time, a.pc);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            cmp("pc", e.pc, a.pc);
            cmp("ax", e.ax, a.ax);
            cmp("bx", e.bx, a.bx);
            cmp("cx", e.cx, a.cx);
            cmp("sp", e.sp, a.sp);
            cmp("bp", e.bp, a.bp);
            cmp("ma", e.ma, a.ma);
            cmp("error_code", {13'd0, e.err}, {13'd0, a.err});
            cmp("code_access_warning", {15'd0, e.warn}, {15'd0, a.warn});
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_wr_en = 0;
    logic [11:0] cfg_wr_data = '0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [1:0]  s_opcode = '0;
    logic [15:0] s_instr_word = '0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [15:0] m_pc;
    logic signed [15:0] m_ax, m_bx, m_cx, m_sp, m_bp, m_ma;
    logic [2:0]  m_error_code;
    logic        m_code_access_warning;

    cpu_scoreboard sb = new();
    int  words_sent = 0;
    int  words_recv = 0;
    bit  send_quiet = 0;

    stack_cpu16_instruction_executor_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_opcode(s_opcode), .s_instr_word(s_instr_word),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_pc(m_pc), .m_ax(m_ax), .m_bx(m_bx), .m_cx(m_cx),
        .m_sp(m_sp), .m_bp(m_bp), .m_ma(m_ma),
        .m_error_code(m_error_code),
        .m_code_access_warning(m_code_access_warning)
    );

    always #4 aclk = ~aclk;

    // monitor both channels and the config port
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en) sb.set_start(cfg_wr_data);
            if (s_valid && s_ready) sb.note_input(s_opcode, s_instr_word);
            if (m_valid && m_ready)
                sb.check_result({m_pc, m_ax, m_bx, m_cx, m_sp, m_bp, m_ma,
                                 m_error_code, m_code_access_warning});
        end
    end

    // instruction encoders
    function automatic logic [15:0] ins_imm(instr_op_t op, logic [7:0] imm, logic [2:0] d);
        return {op, 1'b0, imm, d};
    endfunction

    function automatic logic [15:0] ins_reg(instr_op_t op, logic [2:0] s, logic [2:0] d);
        return {op, 1'b1, 5'd0, s, d};
    endfunction

    function automatic logic [15:0] ins_wide(instr_op_t op, logic [10:0] imm);
        return {op, 1'b0, imm};
    endfunction

    function automatic logic [2:0] pick_reg();
        if ($urandom_range(0, 15) == 0) return 3'($urandom_range(6, 7));
        return 3'($urandom_range(0, 5));
    endfunction

    // random instruction with branch targets inside the program or zero, and some bad registers
    function automatic logic [15:0] rand_instr(logic [11:0] base, int len);
        instr_op_t op;
        logic [11:0] tgt;
        op = instr_op_t'($urandom_range(0, 15));
        tgt = base + 12'($urandom_range(0, len - 1));
        if ($urandom_range(0, 19) == 0) tgt = 12'd0;
        case (op)
            OP_JMP, OP_JNZ, OP_JZ, OP_JN, OP_CALL: return {op, tgt};
            OP_PUSH, OP_STORE: begin
                if ($urandom_range(0, 1)) return ins_reg(op, pick_reg(), 3'($urandom));
                return ins_wide(op, 11'($urandom));
            end
            default: begin
                if ($urandom_range(0, 3) == 0)
                    return ins_imm($urandom_range(0, 1) ? OP_MOV : OP_MULT,
                                   8'($urandom), R_MA);
                if ($urandom_range(0, 1)) return ins_reg(op, pick_reg(), pick_reg());
                return ins_imm(op, 8'($urandom), pick_reg());
            end
        endcase
    endfunction

    // offer one input word with a random gap before it, or none while the sender is quiet
    task automatic send_word(item_op_t op, logic [15:0] word);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(negedge aclk);
        end
        s_opcode <= op;
        s_instr_word <= word;
        s_valid <= 1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
        if (words_sent % 40 == 0) send_quiet = ($urandom_range(0, 3) == 0);
        @(negedge aclk);
    endtask

    // pause the sender until every result word has come back
    task automatic drain();
        s_valid <= 0;
        while (sb.pending_q.size() > 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_start(logic [11:0] v);
        cfg_wr_en <= 1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 0;
        @(negedge aclk);
    endtask

    // random restart, load or idle word, or execute when safe, otherwise restart or load
    task automatic step_cpu();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) send_word(ITEM_RESTART, 16'($urandom));
        else if (r < 8) send_word(ITEM_LOAD, 16'($urandom));
        else if (r < 11) send_word(ITEM_NONE, 16'($urandom));
        else if (sb.exec_safe()) send_word(ITEM_EXEC, 16'($urandom));
        else if ($urandom_range(0, 1)) send_word(ITEM_RESTART, 16'($urandom));
        else send_word(ITEM_LOAD, 16'($urandom));
    endtask

    // receiver with random stalls and one long hold-off
    initial begin
        int w;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            w = ((words_recv / 32) % 4 == 1) ? 0 : $urandom_range(0, 13);
            if (words_recv == 200) w = 400;
            if (w > 0) begin
                m_ready <= 0;
                repeat (w) @(negedge aclk);
            end
            m_ready <= 1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            words_recv++;
            @(negedge aclk);
        end
    end

    // stimulus
    initial begin
        logic [15:0] prog [$];
        logic [11:0] base;
        int len;
        int phase;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // directed program at the reset start address
        prog = '{ins_imm(OP_MOV, 8'd128, R_AX), ins_imm(OP_MULT, 8'd255, R_AX),
                 ins_imm(OP_ADD, 8'd128, R_AX), ins_imm(OP_MOV, 8'd1, R_BX),
                 ins_imm(OP_SUB, 8'd2, R_BX), ins_reg(OP_DIV, R_BX, R_AX),
                 ins_wide(OP_PUSH, 11'h7ff), ins_imm(OP_POP, 8'd0, R_BP),
                 ins_imm(OP_MOV, 8'd0, R_MA), ins_wide(OP_STORE, 11'h7ff),
                 ins_imm(OP_LOAD, 8'd0, R_AX), ins_imm(OP_DIV, 8'd0, R_AX)};
        foreach (prog[i]) send_word(ITEM_LOAD, prog[i]);
        send_word(ITEM_RESTART, 16'hffff);
        foreach (prog[i]) send_word(ITEM_EXEC, 16'h0000);
        send_word(ITEM_EXEC, 16'hffff);
        send_word(ITEM_NONE, 16'h0000);

        // random programs under several start addresses
        phase = 0;
        while (words_sent < 1000) begin
            drain();
            case (phase % 4)
                0: base = 12'd0;
                1: base = 12'hfff;
                default: base = 12'($urandom);
            endcase
            write_start(base);
            len = $urandom_range(8, 30);
            // prologue puts the stack pointer back at its base
            send_word(ITEM_LOAD, ins_imm(OP_MOV, 8'd32, R_SP));
            send_word(ITEM_LOAD, ins_imm(OP_MULT, 8'd128, R_SP));
            for (int i = 2; i < len; i++) send_word(ITEM_LOAD, rand_instr(base, len));
            send_word(ITEM_RESTART, 16'($urandom));
            repeat (60) step_cpu();
            phase++;
        end

        drain();
        repeat (40) @(negedge aclk);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #8000000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

[stack_cpu16_instruction_executor_top.f]
design/stkcpu_pkg.sv
design/stack_cpu16_instruction_executor_top.sv
sim/tb_top.sv
